// File: design/box_filter_3x3_rgb_macros.svh
// Assertion macros for the 3x3 box filter checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BOX_FILTER_3X3_RGB_MACROS_SVH
`define BOX_FILTER_3X3_RGB_MACROS_SVH

// same-cycle implication, masked during reset
`define BF3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define BF3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after a reset cycle
`define BF3_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// File: design/bf3_pkg.sv
// Shared types, constants and arithmetic helpers of the 3x3 box filter.
// No dependencies; imported by box_filter_3x3_rgb.
package bf3_pkg;

  localparam int PixW         = 8;
  localparam int FrameWidthW  = 12;
  localparam int FrameHeightW = 13;
  localparam int CfgDataW     = 13;
  localparam int SumW         = 12;   // nine 8-bit terms
  localparam int NumRes       = 4;    // results one pixel can cause
  localparam int ResIdxW      = 2;
  localparam int Div9Recip    = 7282; // ceil(2^16 / 9), exact for sums below 2296
  localparam int Div9Shift    = 16;
  localparam int ProdW        = 26;

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 13'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  typedef logic [SumW-1:0] sum_t;

  function automatic logic [PixW-1:0] div9(sum_t s);
    logic [ProdW-1:0] p;
    p = ProdW'(s) * ProdW'(Div9Recip);
    return p[Div9Shift +: PixW];
  endfunction

  function automatic sum_t add9(logic [PixW-1:0] a, logic [PixW-1:0] b, logic [PixW-1:0] c,
                                logic [PixW-1:0] d, logic [PixW-1:0] e, logic [PixW-1:0] f,
                                logic [PixW-1:0] g, logic [PixW-1:0] h, logic [PixW-1:0] k);
    return sum_t'(a) + sum_t'(b) + sum_t'(c) + sum_t'(d) + sum_t'(e)
         + sum_t'(f) + sum_t'(g) + sum_t'(h) + sum_t'(k);
  endfunction

  // mean of nine pixels, each channel on its own
  function automatic pixel_t mean9(pixel_t a, pixel_t b, pixel_t c, pixel_t d, pixel_t e,
                                   pixel_t f, pixel_t g, pixel_t h, pixel_t k);
    pixel_t m;
    m.blue  = div9(add9(a.blue, b.blue, c.blue, d.blue, e.blue,
                        f.blue, g.blue, h.blue, k.blue));
    m.green = div9(add9(a.green, b.green, c.green, d.green, e.green,
                        f.green, g.green, h.green, k.green));
    m.red   = div9(add9(a.red, b.red, c.red, d.red, e.red,
                        f.red, g.red, h.red, k.red));
    return m;
  endfunction

endpackage

// File: design/box_filter_3x3_rgb.sv
// Streaming 3x3 mean filter with edge replication for 24-bit BGR pixels.
// Depends on bf3_pkg.
//
// Pixels enter in raster order; results for row y-1 leave while row y enters,
// one column behind, and the last row is finished during the last row itself.
// The block takes one pixel per clock while each pixel yields at most one
// result and the output does not stall; a pixel that ends a row yields two,
// and on the last row up to four, and since the result register bank drains
// one result per clock while out_stall is low, input stalls for the extra
// results. A result leaves the bank once its last pixel, with its registered
// line store read, has passed the window stage, whose window sums are
// registered into the result bank.
// Two line stores of MAX_WIDTH x 24 bits hold the previous two rows; they
// have no reset and no clearing pass. Frame size writes take effect at once.
module box_filter_3x3_rgb
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PixW-1:0]     in_blue,
  input  logic [PixW-1:0]     in_green,
  input  logic [PixW-1:0]     in_red,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COL_W-1:0]    out_col,
  output logic [ROW_W-1:0]    out_row,
  output logic [PixW-1:0]     out_blue,
  output logic [PixW-1:0]     out_green,
  output logic [PixW-1:0]     out_red,
  output logic                run_last
);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           pix;
  } res_t;

  // configuration
  logic [FrameWidthW-1:0]  frame_width;
  logic [FrameHeightW-1:0] frame_height;
  logic [COL_W-1:0]        width_m1;
  logic [ROW_W-1:0]        height_m1;

  // input side counters
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             in_accept;
  logic             in_last_col;
  logic             in_last_row;

  // line stores
  pixel_t older_line [MAX_WIDTH];
  pixel_t newer_line [MAX_WIDTH];

  // window stage
  logic             s1_valid;
  logic             s1_fire;
  pixel_t           s1_pix;
  pixel_t           s1_older;
  pixel_t           s1_newer;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last_col;
  logic             s1_last_row;
  pixel_t           cur [3];
  pixel_t           lft [3];
  pixel_t           win0 [3];
  pixel_t           win1 [3];
  pixel_t           top0;
  pixel_t           top1;
  pixel_t           topc;
  pixel_t           topl;
  res_t             res_next [NumRes];
  logic [NumRes-1:0] res_vld;

  // result bank
  res_t              res_q [NumRes];
  logic [NumRes-1:0] res_mask;
  logic [ResIdxW-1:0] sel_idx;
  logic              out_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameWidthReset;
      frame_height <= FrameHeightReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FrameWidthW-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // clamp the frame size to 1..MAX
  always_comb begin
    int w;
    int h;
    w = int'(frame_width);
    h = int'(frame_height);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    width_m1  = COL_W'(w - 1);
    height_m1 = ROW_W'(h - 1);
  end

  assign in_accept   = in_valid && !in_stall;
  assign in_last_col = col_count >= width_m1;
  assign in_last_row = row_count >= height_m1;
  assign out_accept  = out_valid && !out_stall;

  // the stage moves on once the bank is empty or its last result leaves now
  assign s1_fire  = s1_valid && (res_mask == '0 || (out_accept && run_last));
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (in_last_col) begin
        col_count <= '0;
        row_count <= in_last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // line stores: rows shift when a request leaves the window stage; a read
  // of the column being written in the same cycle takes the new data
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      older_line[s1_col] <= s1_newer;
      newer_line[s1_col] <= s1_pix;
    end
    if (in_accept) begin
      if (s1_fire && s1_col == col_count) begin
        s1_older <= s1_newer;
        s1_newer <= s1_pix;
      end else begin
        s1_older <= older_line[col_count];
        s1_newer <= newer_line[col_count];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_pix      <= '{red: in_red, green: in_green, blue: in_blue};
      s1_col      <= col_count;
      s1_row      <= row_count;
      s1_last_col <= in_last_col;
      s1_last_row <= in_last_row;
    end
  end

  // current column, top to bottom; rows above the frame replicate the top row
  assign cur[0] = (s1_row > ROW_W'(1)) ? s1_older : s1_newer;
  assign cur[1] = s1_newer;
  assign cur[2] = s1_pix;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lft[i] = (s1_col == '0) ? cur[i] : win1[i];
    end
    // last row: rows below replicate the bottom row
    top0 = (s1_row != '0) ? win0[1] : win0[2];
    top1 = (s1_row != '0) ? win1[1] : win1[2];
    topc = (s1_row != '0) ? cur[1]  : cur[2];
    topl = (s1_row != '0) ? lft[1]  : lft[2];

    res_vld[0] = (s1_row != '0) && (s1_col != '0);
    res_vld[1] = (s1_row != '0) && s1_last_col;
    res_vld[2] = s1_last_row && (s1_col != '0);
    res_vld[3] = s1_last_row && s1_last_col;

    res_next[0].col = s1_col - 1'b1;
    res_next[0].row = s1_row - 1'b1;
    res_next[0].pix = mean9(win0[0], win0[1], win0[2], win1[0], win1[1], win1[2],
                            cur[0], cur[1], cur[2]);
    res_next[1].col = s1_col;
    res_next[1].row = s1_row - 1'b1;
    res_next[1].pix = mean9(lft[0], lft[1], lft[2], cur[0], cur[1], cur[2],
                            cur[0], cur[1], cur[2]);
    res_next[2].col = s1_col - 1'b1;
    res_next[2].row = s1_row;
    res_next[2].pix = mean9(top0, win0[2], win0[2], top1, win1[2], win1[2],
                            topc, cur[2], cur[2]);
    res_next[3].col = s1_col;
    res_next[3].row = s1_row;
    res_next[3].pix = mean9(topl, lft[2], lft[2], topc, cur[2], cur[2],
                            topc, cur[2], cur[2]);
  end

  // window: columns x-2 and x-1; a new row starts replicated
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win0[i] <= '0;
        win1[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        win0[i] <= lft[i];
        win1[i] <= cur[i];
      end
    end
  end

  // result bank: pending results leave lowest slot first
  always_comb begin
    sel_idx = '0;
    for (int i = NumRes - 1; i >= 0; i--) begin
      if (res_mask[i]) sel_idx = ResIdxW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_mask <= '0;
    end else if (s1_fire) begin
      res_mask <= res_vld;
    end else if (out_accept) begin
      res_mask <= res_mask & ~(NumRes'(1) << sel_idx);
    end
    if (s1_fire) begin
      for (int i = 0; i < NumRes; i++) begin
        res_q[i] <= res_next[i];
      end
    end
  end

  assign out_valid = |res_mask;
  assign run_last  = (res_mask >> sel_idx) == NumRes'(1);
  assign out_col   = res_q[sel_idx].col;
  assign out_row   = res_q[sel_idx].row;
  assign out_blue  = res_q[sel_idx].pix.blue;
  assign out_green = res_q[sel_idx].pix.green;
  assign out_red   = res_q[sel_idx].pix.red;

endmodule

// File: design/bf3_checker.sv
// Port-level checker for box_filter_3x3_rgb, bound to every instance.
// Depends on box_filter_3x3_rgb_macros.svh.
`include "box_filter_3x3_rgb_macros.svh"

module bf3_checker #(
  parameter int COL_W = 11,
  parameter int ROW_W = 12
) (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [COL_W-1:0] out_col,
  input logic [ROW_W-1:0] out_row,
  input logic [7:0]       out_blue,
  input logic [7:0]       out_green,
  input logic [7:0]       out_red,
  input logic             run_last
);

  `BF3_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BF3_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_col) && $stable(out_row) && $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(run_last), "stalled result changed")
  // input only backs up behind pending results
  `BF3_ASSERT_IMPLY(a_stall_cause, clk, rst, in_stall, out_valid, "input stalled with no pending result")
  `BF3_ASSERT_RESET(a_reset_idle, clk, rst, !out_valid && !in_stall, "not idle after reset")

endmodule

bind box_filter_3x3_rgb bf3_checker #(.COL_W(COL_W), .ROW_W(ROW_W)) u_bf3_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the streaming 3x3 box filter (box_filter_3x3_rgb).
// Depends on bf3_pkg. A local predictor tracks the line stores, window and counters;
// named tests drive frames of pixels, and one checker compares every filtered result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bf3_pkg::*;

  localparam int MaxWidth     = 2048;
  localparam int MaxHeight    = 4096;
  localparam int ColW         = 11;
  localparam int RowW         = 12;
  localparam int DrainCycles  = 8;
  localparam int LongHold     = 300;
  localparam int StallLimit   = 2000;
  localparam int MismatchShow = 10;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    pixel_t          mean;
    logic            last;
  } box_result_t;

  // one column of the window, top row first
  typedef pixel_t column_t [3];

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  cfg_reg_t            cfg_index = REG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PixW-1:0]     in_blue = '0;
  logic [PixW-1:0]     in_green = '0;
  logic [PixW-1:0]     in_red = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ColW-1:0]     out_col;
  logic [RowW-1:0]     out_row;
  logic [PixW-1:0]     out_blue;
  logic [PixW-1:0]     out_green;
  logic [PixW-1:0]     out_red;
  logic                run_last;

  box_filter_3x3_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .run_last  (run_last)
  );

  always #2 clk = ~clk;

  // predictor state
  pixel_t      row_above2 [MaxWidth];
  pixel_t      row_above1 [MaxWidth];
  column_t     win_far;
  column_t     win_near;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned reg_width;
  int unsigned reg_height;

  box_result_t pending_means [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_in = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic box_result_t box_mean(input int unsigned col, input int unsigned row,
                                           input column_t lf, input column_t ce,
                                           input column_t rt, input int unsigned top,
                                           input int unsigned mid);
    int unsigned sb, sg, sr, r;
    int unsigned pick [3];
    box_result_t res;
    pick[0] = top;
    pick[1] = mid;
    pick[2] = 2;
    sb = 0;
    sg = 0;
    sr = 0;
    foreach (pick[i]) begin
      r = pick[i];
      sb += lf[r].blue + ce[r].blue + rt[r].blue;
      sg += lf[r].green + ce[r].green + rt[r].green;
      sr += lf[r].red + ce[r].red + rt[r].red;
    end
    res.col = ColW'(col);
    res.row = RowW'(row);
    res.mean.blue = PixW'(sb / 9);
    res.mean.green = PixW'(sg / 9);
    res.mean.red = PixW'(sr / 9);
    res.last = 1'b0;
    return res;
  endfunction

  task automatic predict_box_means(input pixel_t px);
    int unsigned w, h, x, y, ix, top;
    bit end_col, end_row;
    column_t cur, lcol;
    box_result_t res [$];
    w = clamp_dim(reg_width, MaxWidth);
    h = clamp_dim(reg_height, MaxHeight);
    x = col_pos;
    y = row_pos;
    end_col = (x >= w - 1);
    end_row = (y >= h - 1);
    ix = x % MaxWidth;
    cur[0] = (y >= 2) ? row_above2[ix] : row_above1[ix];
    cur[1] = row_above1[ix];
    cur[2] = px;
    // first column of a row replicates the left edge
    if (x == 0) lcol = cur;
    else lcol = win_near;
    if (y >= 1) begin
      if (x >= 1) res.push_back(box_mean(x - 1, y - 1, win_far, win_near, cur, 0, 1));
      if (end_col) res.push_back(box_mean(x, y - 1, lcol, cur, cur, 0, 1));
    end
    if (end_row) begin
      top = (y >= 1) ? 1 : 2;
      if (x >= 1) res.push_back(box_mean(x - 1, y, win_far, win_near, cur, top, 2));
      if (end_col) res.push_back(box_mean(x, y, lcol, cur, cur, top, 2));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_means.push_back(res[i]);
    win_far = lcol;
    win_near = cur;
    row_above2[ix] = row_above1[ix];
    row_above1[ix] = px;
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    pixels_in++;
  endtask

  // pixels still needed to close the current frame at the present settings
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, rem_row, rows_after;
    w = clamp_dim(reg_width, MaxWidth);
    h = clamp_dim(reg_height, MaxHeight);
    rem_row = (col_pos >= w - 1) ? 1 : w - col_pos;
    rows_after = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
    return rem_row + rows_after * w;
  endfunction

  function automatic logic [PixW-1:0] random_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  // one request: optional idle cycles, then hold it until taken
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= px.blue;
    in_green <= px.green;
    in_red <= px.red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_box_means(px);
  endtask

  task automatic drive_pixels(input pixel_t burst [$]);
    foreach (burst[i]) send_pixel(burst[i]);
    in_valid <= 1'b0;
  endtask

  task automatic send_random(input int unsigned count);
    pixel_t burst [$];
    repeat (count) burst.push_back({random_channel(), random_channel(), random_channel()});
    drive_pixels(burst);
  endtask

  // all results in, then enough cycles for a pixel that yields none to settle
  task automatic wait_idle();
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_frame(input logic [CfgDataW-1:0] wdata,
                               input logic [CfgDataW-1:0] hdata);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= wdata;
    @(posedge clk);
    reg_width = wdata[FrameWidthW-1:0];
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= hdata;
    @(posedge clk);
    reg_height = hdata[FrameHeightW-1:0];
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic note_mismatch(input string what, input box_result_t want,
                               input box_result_t got);
    mismatches++;
    if (mismatches <= MismatchShow) begin
      $display("%s: want col %0d row %0d bgr %0d/%0d/%0d last %0b,",
               what, want.col, want.row, want.mean.blue, want.mean.green, want.mean.red,
               want.last);
      $display("  got col %0d row %0d bgr %0d/%0d/%0d last %0b",
               got.col, got.row, got.mean.blue, got.mean.green, got.mean.red, got.last);
    end
  endtask

  always @(posedge clk) begin
    box_result_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got.col = out_col;
      got.row = out_row;
      got.mean.blue = out_blue;
      got.mean.green = out_green;
      got.mean.red = out_red;
      got.last = run_last;
      results_seen++;
      if (pending_means.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_means.pop_front();
        if (want != got) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // receiver side: random stalls, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LongHold;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no request moved for %0d cycles", quiet_cycles);
      $display("box_filter_3x3_rgb: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reset_predictor();
    foreach (row_above1[i]) begin
      row_above1[i] = '0;
      row_above2[i] = '0;
    end
    foreach (win_far[i]) begin
      win_far[i] = '0;
      win_near[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    reg_width = FrameWidthReset;
    reg_height = FrameHeightReset;
  endtask

  // a few pixels at the 640x480 reset size, then shrink so the frame closes
  task automatic test_reset_defaults();
    send_random(3);
    program_frame(13'd3, 13'd2);
    send_random(pixels_to_frame_end());
  endtask

  // zero registers clamp to a 1x1 frame: the result is the pixel itself
  task automatic test_degenerate_frames();
    pixel_t burst [$];
    program_frame(13'd0, 13'd0);
    burst.push_back('0);
    burst.push_back('1);
    drive_pixels(burst);
  endtask

  task automatic test_small_frame_edges();
    pixel_t burst [$];
    pixel_t px;
    program_frame(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) begin
      px.blue = (i % 2 == 0) ? 8'hFF : 8'h00;
      px.green = (i < 4) ? 8'hFF : 8'h00;
      px.red = PixW'(i * 31);
      burst.push_back(px);
    end
    drive_pixels(burst);
  endtask

  // shrink mid-frame; bit 12 of the width write is dropped by the register
  task automatic test_live_resize();
    program_frame(13'd4, 13'd5);
    send_random(5);
    program_frame(13'h1002, 13'd2);
    send_random(pixels_to_frame_end());
  endtask

  // oversized width clamps to 2048; narrow mid-row so the frame closes quickly
  task automatic test_widest_frame();
    program_frame(13'h1FFF, 13'd1);
    send_random(6);
    program_frame(13'd7, 13'd1);
    send_random(pixels_to_frame_end());
  endtask

  // oversized height clamps to 4096; lower it after a few rows
  task automatic test_tallest_frame();
    program_frame(13'd1, 13'h1FFF);
    send_random(4);
    program_frame(13'd1, 13'd5);
    send_random(pixels_to_frame_end());
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned sent, w, h, n, cut;
    sent = 0;
    while (sent < budget) begin
      w = $urandom_range(7, 1);
      h = $urandom_range(5, 1);
      program_frame(CfgDataW'(w), CfgDataW'(h));
      n = w * h;
      if (n > 1 && $urandom_range(3) == 0) begin
        cut = $urandom_range(n - 1, 1);
        send_random(cut);
        sent += cut;
        // never widen mid-frame: the line stores hold only the narrower rows
        program_frame(CfgDataW'($urandom_range(w, 1)), CfgDataW'($urandom_range(6, 1)));
        n = pixels_to_frame_end();
      end
      send_random(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    program_frame(13'd8, 13'd4);
    holds_asked++;
    send_random(32);
  endtask

  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 51;
    test_reset_defaults();
    test_degenerate_frames();
    test_small_frame_edges();
    test_live_resize();
    test_widest_frame();
    test_tallest_frame();
    test_random_frames(12);

    send_idle_pct = 51;
    recv_idle_pct = 30;
    test_random_frames(12);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(12);
    test_backpressure();

    wait_idle();
    $display("run covered %0d pixels and %0d filtered results over %0d frame settings,",
             pixels_in, results_seen, settings_used);
    $display("including clamped and oversized sizes, mid-frame resizes and a long hold-off");
    if (mismatches == 0) begin
      $display("box_filter_3x3_rgb: match");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("box_filter_3x3_rgb: mismatch");
    end
    $finish;
  end

endmodule
